// ===== hdl/fbpa_pkg.sv =====
package fbpa_pkg;

  localparam int MAX_BLOCKS_DEF = 256;
  localparam int ADDR_WIDTH_DEF = 32;

  localparam int WORD_W = 32;
  localparam int BS_W   = 16;
  localparam int NB_W   = 9;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 3;
  localparam int IDX_REG_W = 2;

  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_INIT  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NULL    = 3'd2;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

  localparam logic [IDX_REG_W-1:0] REG_BASE  = 2'd0;
  localparam logic [IDX_REG_W-1:0] REG_BSIZE = 2'd1;
  localparam logic [IDX_REG_W-1:0] REG_NBLK  = 2'd2;

  localparam logic [WORD_W-1:0] BASE_RST  = 32'd0;
  localparam logic [BS_W-1:0]   BSIZE_RST = 16'd32;
  localparam logic [NB_W-1:0]   NBLK_RST  = 9'd10;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] block_address;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] address;
    logic [STAT_W-1:0] status;
    logic [NB_W-1:0]   free_remaining;
  } result_t;

  typedef enum logic [1:0] {
    ALU_HOLD,
    ALU_LOAD,
    ALU_ADD
  } alu_op_t;

endpackage

// ===== hdl/fbpa_alu.sv =====
module fbpa_alu #(
  parameter int EW = 33
) (
  input  logic              clk,
  input  fbpa_pkg::alu_op_t op,
  input  logic [EW-1:0]     a,
  input  logic [EW-1:0]     b,
  output logic [EW-1:0]     y
);

  // accumulator: load a, then add b per step
  always_ff @(posedge clk) begin
    unique case (op)
      fbpa_pkg::ALU_LOAD: y <= a;
      fbpa_pkg::ALU_ADD:  y <= y + b;
      default:            y <= y;
    endcase
  end

endmodule

// ===== hdl/fbpa_stack.sv =====
module fbpa_stack #(
  parameter int DEPTH = 256,
  parameter int W     = 32,
  parameter int IW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [IW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fixed_block_pool_allocator.sv =====
// Fixed-size block pool allocator with a LIFO stack of free block addresses.
// Command channel: a word on cmd is taken at a clock edge where start is high
// and busy is low. func selects allocate, free or initialize.
// Result channel: done is high for exactly one cycle with the result word.
// The receiver cannot stall; it must take the word in that cycle.
// Config port: wr_en/wr_index/wr_data writes base_address (0), blk_bytes (1)
// and blk_total (2); write only while busy is low and no result is pending.
// Steps from accept to the edge that raises done:
//   allocate: S_POP (stack read through the registered memory port),
//   allocate on empty pool and unused func: done raised from S_IDLE,
//   free: span multiply, bound add on the shared adder, check and push,
//   initialize: one stack write and one shared-adder step per block for
//   n = min(blk_total, MAX_BLOCKS) blocks, then done.
// One command is in flight at a time; a new command may be taken in the
// cycle done is high.
// Reset clears the free count to zero and loads the config reset values;
// stack contents are undefined until written and need no clearing pass.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_WIDTH = fbpa_pkg::ADDR_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  fbpa_pkg::cmd_t                      cmd,
  output logic                                done,
  output fbpa_pkg::result_t                   result,
  input  logic                                wr_en,
  input  logic [fbpa_pkg::IDX_REG_W-1:0]      wr_index,
  input  logic [fbpa_pkg::WORD_W-1:0]         wr_data
);

  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int SPAN_W = fbpa_pkg::BS_W + CNT_W;
  localparam int EW     = ((ADDR_WIDTH > SPAN_W) ? ADDR_WIDTH : SPAN_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_MUL,
    S_BOUND,
    S_CHECK,
    S_FILL
  } state_t;

  state_t state;

  logic [fbpa_pkg::WORD_W-1:0] base_address;
  logic [fbpa_pkg::BS_W-1:0]   blk_bytes;
  logic [fbpa_pkg::NB_W-1:0]   blk_total;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      idx;
  logic [ADDR_WIDTH-1:0] req_addr;
  logic [SPAN_W-1:0]     span;

  logic [fbpa_pkg::WORD_W-1:0] res_addr;
  logic [fbpa_pkg::STAT_W-1:0] res_status;
  logic [CNT_W-1:0]            res_count;

  logic [CNT_W-1:0]      n_blocks;
  logic [63:0]           base_wide;
  logic [63:0]           cmd_addr_wide;
  logic [63:0]           rd_wide;
  logic [31:0]           cnt_wide;
  logic [ADDR_WIDTH-1:0] base_a;
  logic [EW-1:0]         base_e;
  logic [EW-1:0]         addr_e;
  logic [CNT_W-1:0]      count_m1;
  logic                  pool_empty;
  logic                  is_null;
  logic                  is_outside;
  logic                  is_full;
  logic                  fill_end;

  fbpa_pkg::alu_op_t alu_op;
  logic [EW-1:0]     alu_b;
  logic [EW-1:0]     alu_y;

  logic                  st_we;
  logic [IDX_W-1:0]      st_waddr;
  logic [ADDR_WIDTH-1:0] st_wdata;
  logic [IDX_W-1:0]      st_raddr;
  logic [ADDR_WIDTH-1:0] st_rdata;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= fbpa_pkg::BASE_RST;
      blk_bytes    <= fbpa_pkg::BSIZE_RST;
      blk_total    <= fbpa_pkg::NBLK_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        fbpa_pkg::REG_BASE:  base_address <= wr_data;
        fbpa_pkg::REG_BSIZE: blk_bytes    <= wr_data[fbpa_pkg::BS_W-1:0];
        fbpa_pkg::REG_NBLK:  blk_total    <= wr_data[fbpa_pkg::NB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(blk_total) > 32'(MAX_BLOCKS)) begin
      n_blocks = CNT_W'(MAX_BLOCKS);
    end else begin
      n_blocks = CNT_W'(blk_total);
    end
  end

  assign base_wide     = 64'(base_address);
  assign cmd_addr_wide = 64'(cmd.block_address);
  assign rd_wide       = 64'(st_rdata);
  assign cnt_wide      = 32'(res_count);
  assign base_a        = base_wide[ADDR_WIDTH-1:0];
  assign base_e        = EW'(base_a);
  assign addr_e        = EW'(req_addr);
  assign count_m1      = count - CNT_W'(1);

  assign pool_empty = (count == '0) || (32'(count) > 32'(MAX_BLOCKS));
  assign is_null    = (req_addr == '0);
  assign is_outside = (addr_e < base_e) || (addr_e >= alu_y);
  assign is_full    = (count >= n_blocks);
  assign fill_end   = (idx == n_blocks);

  assign busy = (state != S_IDLE);

  // shared adder control
  always_comb begin
    alu_op = fbpa_pkg::ALU_HOLD;
    alu_b  = EW'(blk_bytes);
    unique case (state)
      S_IDLE: begin
        if (start && (cmd.func == fbpa_pkg::FN_FREE || cmd.func == fbpa_pkg::FN_INIT)) begin
          alu_op = fbpa_pkg::ALU_LOAD;
        end
      end
      S_BOUND: begin
        alu_op = fbpa_pkg::ALU_ADD;
        alu_b  = EW'(span);
      end
      S_FILL: begin
        if (!fill_end) begin
          alu_op = fbpa_pkg::ALU_ADD;
        end
      end
      default: ;
    endcase
  end

  // stack port
  always_comb begin
    st_raddr = count_m1[IDX_W-1:0];
    if (state == S_FILL) begin
      st_we    = !fill_end;
      st_waddr = idx[IDX_W-1:0];
      st_wdata = alu_y[ADDR_WIDTH-1:0];
    end else begin
      st_we    = (state == S_CHECK) && !is_null && !is_outside && !is_full;
      st_waddr = count[IDX_W-1:0];
      st_wdata = req_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_addr <= cmd_addr_wide[ADDR_WIDTH-1:0];
            idx      <= '0;
            unique case (cmd.func)
              fbpa_pkg::FN_ALLOC: begin
                if (pool_empty) begin
                  done       <= 1'b1;
                  res_addr   <= '0;
                  res_status <= fbpa_pkg::ST_EMPTY;
                  res_count  <= count;
                end else begin
                  count <= count_m1;
                  state <= S_POP;
                end
              end
              fbpa_pkg::FN_FREE: state <= S_MUL;
              fbpa_pkg::FN_INIT: state <= S_FILL;
              default: begin
                done       <= 1'b1;
                res_addr   <= '0;
                res_status <= fbpa_pkg::ST_OK;
                res_count  <= count;
              end
            endcase
          end
        end
        S_POP: begin
          done       <= 1'b1;
          res_addr   <= rd_wide[fbpa_pkg::WORD_W-1:0];
          res_status <= fbpa_pkg::ST_OK;
          res_count  <= count;
          state      <= S_IDLE;
        end
        S_MUL: begin
          span  <= SPAN_W'(blk_bytes) * SPAN_W'(n_blocks);
          state <= S_BOUND;
        end
        S_BOUND: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          done     <= 1'b1;
          res_addr <= '0;
          state    <= S_IDLE;
          if (is_null) begin
            res_status <= fbpa_pkg::ST_NULL;
            res_count  <= count;
          end else if (is_outside) begin
            res_status <= fbpa_pkg::ST_OUTSIDE;
            res_count  <= count;
          end else if (is_full) begin
            res_status <= fbpa_pkg::ST_FULL;
            res_count  <= count;
          end else begin
            res_status <= fbpa_pkg::ST_OK;
            res_count  <= count + CNT_W'(1);
            count      <= count + CNT_W'(1);
          end
        end
        S_FILL: begin
          if (fill_end) begin
            done       <= 1'b1;
            res_addr   <= '0;
            res_status <= fbpa_pkg::ST_OK;
            res_count  <= n_blocks;
            count      <= n_blocks;
            state      <= S_IDLE;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.address        = res_addr;
  assign result.status         = res_status;
  assign result.free_remaining = cnt_wide[fbpa_pkg::NB_W-1:0];

  fbpa_alu #(
    .EW(EW)
  ) u_alu (
    .clk(clk),
    .op (alu_op),
    .a  (base_e),
    .b  (alu_b),
    .y  (alu_y)
  );

  fbpa_stack #(
    .DEPTH(MAX_BLOCKS),
    .W    (ADDR_WIDTH),
    .IW   (IDX_W)
  ) u_stack (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word while busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command produced neither work nor result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(MAX_BLOCKS))
    else $error("free count beyond pool depth");

  a_write_busy: assert property (@(posedge clk) disable iff (rst) st_we |-> busy)
    else $error("stack write outside a command");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic [fbpa_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int POOL_MAX = fbpa_pkg::MAX_BLOCKS_DEF;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  fbpa_pkg::cmd_t cmd = '0;
  logic done;
  fbpa_pkg::result_t result;
  logic wr_en = 1'b0;
  logic [fbpa_pkg::IDX_REG_W-1:0] wr_index = '0;
  logic [fbpa_pkg::WORD_W-1:0] wr_data = '0;

  fixed_block_pool_allocator u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pool model
  logic [fbpa_pkg::WORD_W-1:0] pool_base = fbpa_pkg::BASE_RST;
  logic [fbpa_pkg::BS_W-1:0] pool_bsize = fbpa_pkg::BSIZE_RST;
  logic [fbpa_pkg::NB_W-1:0] pool_nblk = fbpa_pkg::NBLK_RST;
  logic [fbpa_pkg::WORD_W-1:0] free_addrs [POOL_MAX];
  logic [fbpa_pkg::NB_W-1:0] free_top = '0;

  fbpa_pkg::result_t expected_results [$];
  logic [fbpa_pkg::WORD_W-1:0] held_blocks [$];
  int errors = 0;
  int cycle_count = 0;
  bit gappy = 1'b0;
  fbpa_pkg::result_t want;

  function automatic int pool_blocks();
    return (pool_nblk > POOL_MAX) ? POOL_MAX : int'(pool_nblk);
  endfunction

  task automatic predict_pool_op(input fbpa_pkg::cmd_t c, output fbpa_pkg::result_t r);
    int n;
    longint span;
    longint a;
    longint b;
    n = pool_blocks();
    span = longint'(pool_bsize) * n;
    a = longint'(c.block_address);
    b = longint'(pool_base);
    r = '0;
    r.status = fbpa_pkg::ST_OK;
    case (c.func)
      fbpa_pkg::FN_ALLOC: begin
        if (free_top == 0 || free_top > POOL_MAX) begin
          r.status = fbpa_pkg::ST_EMPTY;
        end else begin
          free_top = free_top - 1'b1;
          r.address = free_addrs[free_top];
        end
      end
      fbpa_pkg::FN_FREE: begin
        if (a == 0) begin
          r.status = fbpa_pkg::ST_NULL;
        end else if (a < b || a - b >= span) begin
          r.status = fbpa_pkg::ST_OUTSIDE;
        end else if (free_top >= n) begin
          r.status = fbpa_pkg::ST_FULL;
        end else begin
          free_addrs[free_top] = c.block_address;
          free_top = free_top + 1'b1;
        end
      end
      fbpa_pkg::FN_INIT: begin
        for (int i = 0; i < n; i++)
          free_addrs[i] = pool_base
                          + fbpa_pkg::WORD_W'(i) * fbpa_pkg::WORD_W'(pool_bsize);
        free_top = fbpa_pkg::NB_W'(n);
      end
      default: begin
      end
    endcase
    r.free_remaining = free_top;
  endtask

  task automatic send_cmd(input logic [fbpa_pkg::FUNC_W-1:0] f,
                          input logic [fbpa_pkg::WORD_W-1:0] a);
    fbpa_pkg::cmd_t c;
    fbpa_pkg::result_t r;
    int gap;
    c.func = f;
    c.block_address = a;
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    predict_pool_op(c, r);
    expected_results.push_back(r);
    if (f == fbpa_pkg::FN_ALLOC && r.status == fbpa_pkg::ST_OK)
      held_blocks.push_back(r.address);
    gap = 0;
    if (gappy)
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 30);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fbpa_pkg::IDX_REG_W-1:0] idx,
                           input logic [fbpa_pkg::WORD_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      fbpa_pkg::REG_BASE: pool_base = val;
      fbpa_pkg::REG_BSIZE: pool_bsize = val[fbpa_pkg::BS_W-1:0];
      fbpa_pkg::REG_NBLK: pool_nblk = val[fbpa_pkg::NB_W-1:0];
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  // upper write-data bits are junk for the narrow registers
  task automatic set_config(input logic [fbpa_pkg::WORD_W-1:0] b,
                            input logic [fbpa_pkg::BS_W-1:0] s,
                            input logic [fbpa_pkg::NB_W-1:0] n);
    drain();
    write_reg(fbpa_pkg::REG_BASE, b);
    write_reg(fbpa_pkg::REG_BSIZE, {16'($urandom_range(0, 16'hFFFF)), s});
    write_reg(fbpa_pkg::REG_NBLK, {23'($urandom_range(0, 32'h7F_FFFF)), n});
  endtask

  task automatic test_after_reset();
    send_cmd(fbpa_pkg::FN_ALLOC, $urandom);
    send_cmd(FN_UNUSED, $urandom);
    send_cmd(fbpa_pkg::FN_FREE, '0);
    send_cmd(fbpa_pkg::FN_FREE, 32'd64);
    send_cmd(fbpa_pkg::FN_ALLOC, $urandom);
  endtask

  task automatic test_default_pool();
    send_cmd(fbpa_pkg::FN_INIT, $urandom);
    send_cmd(fbpa_pkg::FN_ALLOC, $urandom);
    send_cmd(fbpa_pkg::FN_ALLOC, $urandom);
    send_cmd(fbpa_pkg::FN_FREE, 32'd288);
    send_cmd(fbpa_pkg::FN_FREE, 32'd320);
    send_cmd(fbpa_pkg::FN_FREE, 32'd0 + 32'd5);
  endtask

  // top of address space, oversized block count, wrapped blocks
  task automatic test_top_of_space();
    set_config(32'hFFFF_FFF0, 16'hFFFF, 9'h1FF);
    send_cmd(fbpa_pkg::FN_INIT, 32'hFFFF_FFFF);
    send_cmd(fbpa_pkg::FN_ALLOC, '0);
    send_cmd(fbpa_pkg::FN_FREE, 32'hFFFF_FFF0 + 32'd255 * 32'hFFFF);
    send_cmd(fbpa_pkg::FN_FREE, 32'hFFFF_FFFF);
    send_cmd(fbpa_pkg::FN_FREE, 32'hFFFF_FFF0);
    send_cmd(fbpa_pkg::FN_FREE, 32'hFFFF_FFEF);
  endtask

  task automatic test_zero_blocks();
    set_config(32'h0000_1000, 16'd16, 9'd0);
    send_cmd(fbpa_pkg::FN_INIT, '0);
    send_cmd(fbpa_pkg::FN_FREE, 32'h0000_1000);
    send_cmd(fbpa_pkg::FN_ALLOC, '0);
  endtask

  task automatic test_base_zero();
    set_config(32'd0, 16'd1, 9'd1);
    send_cmd(fbpa_pkg::FN_INIT, '0);
    send_cmd(fbpa_pkg::FN_ALLOC, '0);
    send_cmd(fbpa_pkg::FN_FREE, '0);
  endtask

  task automatic test_shrink_after_init();
    set_config(32'h8000_0000, 16'd8, 9'd4);
    send_cmd(fbpa_pkg::FN_INIT, '0);
    send_cmd(fbpa_pkg::FN_ALLOC, '0);
    set_config(32'h8000_0000, 16'd8, 9'd2);
    send_cmd(fbpa_pkg::FN_FREE, 32'h8000_0008);
    send_cmd(fbpa_pkg::FN_ALLOC, '0);
  endtask

  task automatic test_random_traffic();
    logic [fbpa_pkg::WORD_W-1:0] b;
    logic [fbpa_pkg::BS_W-1:0] s;
    logic [fbpa_pkg::NB_W-1:0] n;
    logic [fbpa_pkg::WORD_W-1:0] a;
    int sel;
    int k;
    int pick;
    int nb;
    for (int phase = 0; phase < 7; phase++) begin
      sel = (phase < 4) ? phase : $urandom_range(0, 5);
      case (sel)
        0: b = '0;
        1: b = 32'hFFFF_FFFF - $urandom_range(0, 4096);
        default: b = $urandom;
      endcase
      sel = (phase < 4) ? (phase + 1) % 4 : $urandom_range(0, 5);
      case (sel)
        0: s = '0;
        1: s = 16'd1;
        2: s = 16'hFFFF;
        default: s = fbpa_pkg::BS_W'($urandom_range(1, 64));
      endcase
      sel = (phase < 4) ? (phase + 2) % 4 : $urandom_range(0, 6);
      case (sel)
        0: n = '0;
        1: n = 9'd1;
        2: n = 9'd256;
        3: n = fbpa_pkg::NB_W'($urandom_range(257, 511));
        default: n = fbpa_pkg::NB_W'($urandom_range(2, 24));
      endcase
      set_config(b, s, n);
      held_blocks.delete();
      gappy = (phase % 3 != 0);
      send_cmd(fbpa_pkg::FN_INIT, $urandom);
      for (k = 0; k < 64; k++) begin
        sel = $urandom_range(0, 99);
        nb = pool_blocks();
        if (sel < 40) begin
          send_cmd(fbpa_pkg::FN_ALLOC, $urandom);
        end else if (sel < 70 && held_blocks.size() > 0) begin
          pick = $urandom_range(0, held_blocks.size() - 1);
          a = held_blocks[pick];
          held_blocks.delete(pick);
          send_cmd(fbpa_pkg::FN_FREE, a);
        end else if (sel < 85) begin
          if (nb == 0 || pool_bsize == 0)
            a = pool_base + $urandom_range(0, 3);
          else
            a = pool_base
                + fbpa_pkg::WORD_W'($urandom_range(0, nb - 1))
                  * fbpa_pkg::WORD_W'(pool_bsize)
                + fbpa_pkg::WORD_W'($urandom_range(0, pool_bsize - 1));
          send_cmd(fbpa_pkg::FN_FREE, a);
        end else if (sel < 93) begin
          send_cmd(fbpa_pkg::FN_FREE, ($urandom_range(0, 5) == 0) ? '0 : $urandom);
        end else if (sel < 96) begin
          send_cmd(fbpa_pkg::FN_INIT, $urandom);
          held_blocks.delete();
        end else begin
          send_cmd(FN_UNUSED, $urandom);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing pending: address %0h status %0d free %0d",
               result.address, result.status, result.free_remaining);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result.address !== want.address) begin
          $error("address: expected %0h, got %0h", want.address, result.address);
          errors++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          errors++;
        end
        if (result.free_remaining !== want.free_remaining) begin
          $error("free_remaining: expected %0d, got %0d", want.free_remaining,
                 result.free_remaining);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_default_pool();
    test_top_of_space();
    test_zero_blocks();
    test_base_zero();
    test_shrink_after_init();
    test_random_traffic();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
